### rtl/ggh_pkg.sv
// Package with shared constants, types and the arctangent table of the heading controller.
package ggh_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;
  localparam int SqrtSteps    = 25;  // result bits of the square root (d2 < 2^50)
  localparam int SqW          = 50;  // width of dx^2 + dy^2
  localparam int CxW          = 52;  // CORDIC datapath width
  localparam int RtW          = 26;  // root width

  localparam logic [33:0] PiQ24  = 34'd52707179;
  localparam logic [17:0] LimitK = 18'd186122;
  localparam logic [13:0] LinK   = 14'd14418;
  localparam logic [16:0] ErrK   = 17'd72090;

  localparam logic [0:0] CfgSpeedScale     = 1'b0;
  localparam logic [0:0] CfgArriveDistance = 1'b1;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    begin
      unique case (idx)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10679838;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

  // State that travels down the cell chain: valid, CORDIC and root state, yaw and zero flag.
  typedef struct packed {
    logic               vld;
    logic signed [CxW-1:0] x;
    logic signed [CxW-1:0] y;
    logic [31:0]        z;
    logic [SqW-1:0]     rem;
    logic [RtW-1:0]     root;
    logic [15:0]        yaw;
    logic               zero;
  } cell_t;

endpackage

### rtl/ggh_if.sv
// Valid/ready channel interfaces: ggh_in_if for pose transactions, ggh_out_if for command transactions.
interface ggh_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] robot_x;
  logic signed [23:0] robot_y;
  logic signed [15:0] robot_yaw;
  logic signed [23:0] goal_x;
  logic signed [23:0] goal_y;
  modport source (output valid, robot_x, robot_y, robot_yaw, goal_x, goal_y, input ready);
  modport sink (input valid, robot_x, robot_y, robot_yaw, goal_x, goal_y, output ready);
endinterface

interface ggh_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] linear_velocity;
  logic signed [18:0] angular_velocity;
  logic [23:0]        goal_distance;
  logic               at_goal;
  modport source (output valid, linear_velocity, angular_velocity, goal_distance, at_goal,
                  input ready);
  modport sink (input valid, linear_velocity, angular_velocity, goal_distance, at_goal,
                output ready);
endinterface

### rtl/ggh_cell.sv
// One chain cell: one CORDIC vectoring rotation (when do_cordic is set) and one square-root result bit.
module ggh_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [4:0]       stage,
  input  logic             do_cordic,
  input  logic [5:0]       bit_hi,
  input  ggh_pkg::cell_t   c_in,
  output ggh_pkg::cell_t   c_out
);
  import ggh_pkg::*;

  cell_t c_nxt;
  cell_t c_r;
  logic signed [CxW-1:0] xs, ys;
  logic [SqW-1:0] trial, bit_v, rem_t;
  logic [RtW-1:0] root_t;

  always_comb begin
    c_nxt = c_in;
    xs = c_in.x >>> stage;
    ys = c_in.y >>> stage;
    if (do_cordic && !c_in.zero) begin
      if (c_in.y > 0) begin
        c_nxt.x = c_in.x + ys;
        c_nxt.y = c_in.y - xs;
        c_nxt.z = c_in.z + atan_lut(stage);
      end else begin
        c_nxt.x = c_in.x - ys;
        c_nxt.y = c_in.y + xs;
        c_nxt.z = c_in.z - atan_lut(stage);
      end
    end
    // Restoring square root, one result bit p with bit_hi = 2p. The root holds the
    // bits found so far, so the trial value is (root << 2p+2) + 4^p.
    bit_v = '0;
    bit_v[bit_hi] = 1'b1;
    trial = ({{(SqW-RtW){1'b0}}, c_in.root} << (bit_hi + 6'd2)) + bit_v;
    rem_t = c_in.rem;
    root_t = c_in.root << 1;
    if (bit_hi[0] == 1'b0 && rem_t >= trial) begin
      rem_t = rem_t - trial;
      root_t = root_t | {{(RtW-1){1'b0}}, 1'b1};
    end
    c_nxt.rem = rem_t;
    c_nxt.root = root_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r.vld <= c_nxt.vld;
    end
    if (en) begin
      c_r.x <= c_nxt.x; c_r.y <= c_nxt.y; c_r.z <= c_nxt.z;
      c_r.rem <= c_nxt.rem; c_r.root <= c_nxt.root;
      c_r.yaw <= c_nxt.yaw; c_r.zero <= c_nxt.zero;
    end
  end

  assign c_out = c_r;
endmodule

### rtl/go_to_goal_heading_controller_unit.sv
// Top level of the go-to-goal heading controller: input stage, cell chain and output math.
// Pipeline: 1 input stage + 25 chain cells + 3 output stages.
// Throughput: one pose transaction per cycle; the whole pipeline advances together and
// stalls only when the output register is full and not taken.
// Reset (synchronous, active-low rst_n) clears all valid bits and loads speed_scale
// with 29491 and arrive_distance with 6554.
module go_to_goal_heading_controller_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [22:0]  cfg_data,
  ggh_in_if.sink       in_ch,
  ggh_out_if.source    out_ch
);
  import ggh_pkg::*;

  localparam int NCell = SqrtSteps;   // 25 cells; CORDIC runs in the first CordicStages

  logic [16:0] speed_r;
  logic [22:0] arrive_r;
  logic        adv;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= 17'd29491;
      arrive_r <= 23'd6554;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgSpeedScale:     speed_r  <= cfg_data[16:0];
        CfgArriveDistance: arrive_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves when the final register is empty or being taken.
  logic o_vld_r;
  assign adv = !o_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Input stage: differences, squares and CORDIC pre-rotation.
  cell_t s0_r;
  logic signed [24:0] dx, dy;
  logic [49:0] d2;
  always_comb begin
    dx = 25'(in_ch.goal_x) - 25'(in_ch.robot_x);
    dy = 25'(in_ch.goal_y) - 25'(in_ch.robot_y);
  end
  // Squares in the input cycle: two 25x25 products, one per axis.
  logic [49:0] sqx, sqy;
  assign sqx = 50'(dx * dx);
  assign sqy = 50'(dy * dy);
  assign d2  = sqx + sqy;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.vld <= 1'b0;
    else if (adv) s0_r.vld <= in_ch.valid;
    if (adv) begin
      s0_r.zero <= (dx == '0) && (dy == '0);
      s0_r.yaw  <= in_ch.robot_yaw;
      s0_r.rem  <= d2;
      s0_r.root <= '0;
      if (dx < 0) begin
        s0_r.x <= -(CxW'(dx) <<< 24);
        s0_r.y <= -(CxW'(dy) <<< 24);
        s0_r.z <= 32'h8000_0000;
      end else begin
        s0_r.x <= CxW'(dx) <<< 24;
        s0_r.y <= CxW'(dy) <<< 24;
        s0_r.z <= '0;
      end
    end
  end

  // Chain of cells; cell k handles CORDIC stage k (for k below CordicStages) and root bit 24-k.
  cell_t chain [0:NCell];
  assign chain[0] = s0_r;
  for (genvar k = 0; k < NCell; k++) begin : g_cell
    ggh_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .stage(5'(k)),
      .do_cordic(k < CordicStages && k < AtanEntries),
      .bit_hi(6'(2*(NCell-1-k))),
      .c_in(chain[k]), .c_out(chain[k+1])
    );
  end

  // Output stage A: error, magnitude, first products, arrival compare and distance clamp.
  cell_t last;
  assign last = chain[NCell];
  logic [31:0] e;
  logic        neg;
  logic [32:0] mag;
  assign e   = (last.zero ? 32'd0 : last.z) - {last.yaw, 16'd0};
  assign neg = e[31];
  assign mag = neg ? (33'h1_0000_0000 - 33'(e)) : 33'(e);

  logic        a_vld_r, a_neg_r, a_arr_r;
  logic [49:0] a_t_r;      // speed*mag
  logic [49:0] a_me_r;     // mag*ErrK
  logic [34:0] a_lim_r;
  logic [30:0] a_sl_r;     // speed*LinK
  logic [23:0] a_dist_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= last.vld;
    if (adv) begin
      a_neg_r  <= neg;
      a_t_r    <= 50'(speed_r) * 50'(mag);
      a_me_r   <= 50'(mag) * 50'(ErrK);
      a_lim_r  <= 35'(speed_r) * 35'(LimitK) + 35'd32768;
      a_sl_r   <= 31'(speed_r) * 31'(LinK);
      a_arr_r  <= 26'(last.root) < 26'(arrive_r);
      a_dist_r <= last.root[RtW-1:24] != '0 ? 24'hFF_FFFF : last.root[23:0];
    end
  end

  // Stage B: angular scaling product, the clamped limit and the forward gain factor.
  logic        b_vld_r, b_neg_r, b_arr_r;
  logic [63:0] b_ap_r;
  logic [18:0] b_lim_r;
  logic signed [32:0] b_f_r;
  logic [30:0] b_sl_r;
  logic [23:0] b_dist_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= a_vld_r;
    if (adv) begin
      b_neg_r  <= a_neg_r;
      b_arr_r  <= a_arr_r;
      b_dist_r <= a_dist_r;
      b_sl_r   <= a_sl_r;
      b_ap_r   <= 64'(a_t_r[49:20]) * 64'(PiQ24) + 64'h2_0000_0000;
      b_lim_r  <= a_lim_r[34:16] > 19'd262143 ? 19'd262143 : a_lim_r[34:16];
      b_f_r    <= 33'sh0_8000_0000 - 33'(a_me_r[49:16]);
    end
  end

  // Stage C: clamps and the forward product, into the output register.
  logic [29:0] amag;
  logic [18:0] acl;
  logic signed [64:0] lp;
  logic signed [17:0] lin_w;
  logic signed [14:0] lin;
  assign amag  = b_ap_r[63:34];
  assign acl   = (amag > 30'(b_lim_r)) ? b_lim_r : amag[18:0];
  assign lp    = $signed({34'd0, b_sl_r}) * 65'(b_f_r) + 65'sh4000_0000_0000;
  assign lin_w = lp[64:47];
  assign lin   = (lin_w > 18'sd16383) ? 15'sd16383 :
                 (lin_w < -18'sd16384) ? -15'sd16384 : lin_w[14:0];

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (adv) o_vld_r <= b_vld_r;
    if (adv) begin
      out_ch.at_goal          <= b_arr_r;
      out_ch.goal_distance    <= b_dist_r;
      out_ch.linear_velocity  <= b_arr_r ? '0 : lin;
      out_ch.angular_velocity <= b_arr_r ? '0 : (b_neg_r ? -$signed(acl) : $signed(acl));
    end
  end
  assign out_ch.valid = o_vld_r;

  // A stalled result must hold its goal distance.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && !out_ch.ready |=> o_vld_r && $stable(out_ch.goal_distance))
    else $error("result changed while stalled");
  // Arrived results carry zero speeds.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && out_ch.at_goal |-> out_ch.linear_velocity == '0 &&
    out_ch.angular_velocity == '0) else $error("speed nonzero at goal");
  // Ready is high whenever the output register is empty.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !o_vld_r |-> in_ch.ready) else $error("stall with empty output");
endmodule
